// ===== rtl/hrp_pkg.sv =====
// Types, codes and match patterns shared by the request header parser.
// Depends on nothing; every other file imports it.
package hrp_pkg;

	// Parse phases of the request line and headers.
	localparam logic [2:0] PH_METHOD     = 3'd0;
	localparam logic [2:0] PH_PATH_START = 3'd1;
	localparam logic [2:0] PH_PATH       = 3'd2;
	localparam logic [2:0] PH_VERSION    = 3'd3;
	localparam logic [2:0] PH_HEADERS    = 3'd4;
	localparam logic [2:0] PH_ERROR      = 3'd5;

	// Accept header tracking.
	localparam logic [1:0] ACC_SEARCH = 2'd0;
	localparam logic [1:0] ACC_VALUE  = 2'd1;
	localparam logic [1:0] ACC_DONE   = 2'd2;

	// Accept-Encoding header tracking.
	localparam logic [1:0] ENS_NONE  = 2'd0;
	localparam logic [1:0] ENS_LINE  = 2'd1;
	localparam logic [1:0] ENS_GZIP  = 2'd2;
	localparam logic [1:0] ENS_UNSUP = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_PATH    = 2'd0;
	localparam logic [1:0] KIND_VERSION = 2'd1;
	localparam logic [1:0] KIND_ACCEPT  = 2'd2;
	localparam logic [1:0] KIND_SUMMARY = 2'd3;

	// Reported encoding.
	localparam logic [1:0] ENC_NONE  = 2'd0;
	localparam logic [1:0] ENC_GZIP  = 2'd1;
	localparam logic [1:0] ENC_UNSUP = 2'd2;

	// Reported status.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_METHOD = 3'd1;
	localparam logic [2:0] ST_BAD_PATH   = 3'd2;
	localparam logic [2:0] ST_BAD_ENC    = 3'd3;
	localparam logic [2:0] ST_TRUNCATED  = 3'd4;

	localparam logic [2:0] METH_INVALID = 3'd0;

	// Steps of a result pack, emitted lowest first.
	localparam int STEP_DATA    = 0;
	localparam int STEP_DEF0    = 1;
	localparam int STEP_DEF1    = 2;
	localparam int STEP_DEF2    = 3;
	localparam int STEP_SUMMARY = 4;
	localparam int N_STEPS      = 5;

	localparam int METHOD_BYTES = 7;
	localparam int N_METHODS    = 6;
	localparam int ACC_PAT_LEN  = 8;
	localparam int ENC_PAT_LEN  = 17;
	localparam int GZIP_PAT_LEN = 4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_QUERY = 8'h3f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;

	// GET, POST, HEAD, PUT, DELETE, OPTIONS, packed right-aligned.
	localparam logic [8*METHOD_BYTES-1:0] METHOD_WORDS [N_METHODS] = '{
		56'h474554, 56'h504f5354, 56'h48454144, 56'h505554,
		56'h44454c455445, 56'h4f5054494f4e53
	};
	localparam logic [2:0] METHOD_LENS [N_METHODS] = '{
		3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7
	};

	typedef struct packed {
		logic [N_STEPS-1:0] mask;
		logic [1:0]         kind;
		logic [7:0]         data;
		logic [2:0]         meth;
		logic [1:0]         enc;
		logic [2:0]         st;
	} hrp_pack_t;

	function automatic logic [7:0] accept_pat(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h41; // A
			3'd1: c = 8'h63; // c
			3'd2: c = 8'h63; // c
			3'd3: c = 8'h65; // e
			3'd4: c = 8'h70; // p
			3'd5: c = 8'h74; // t
			3'd6: c = 8'h3a; // :
			3'd7: c = 8'h20; // space
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] encoding_pat(input logic [4:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:  c = 8'h41; // A
			5'd1:  c = 8'h63; // c
			5'd2:  c = 8'h63; // c
			5'd3:  c = 8'h65; // e
			5'd4:  c = 8'h70; // p
			5'd5:  c = 8'h74; // t
			5'd6:  c = 8'h2d; // -
			5'd7:  c = 8'h45; // E
			5'd8:  c = 8'h6e; // n
			5'd9:  c = 8'h63; // c
			5'd10: c = 8'h6f; // o
			5'd11: c = 8'h64; // d
			5'd12: c = 8'h69; // i
			5'd13: c = 8'h6e; // n
			5'd14: c = 8'h67; // g
			5'd15: c = 8'h3a; // :
			5'd16: c = 8'h20; // space
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] gzip_pat(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h67; // g
			2'd1: c = 8'h7a; // z
			2'd2: c = 8'h69; // i
			2'd3: c = 8'h70; // p
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/hrp_parser.sv =====
// Byte parser: phase register, method collector and header matchers.
// Builds the result pack for each accepted byte. Depends on hrp_pkg.
module hrp_parser #(
	parameter int METHOD_MAX_CHARS = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_byte,
	input  logic              end_of_request,
	output hrp_pkg::hrp_pack_t pack
);
	import hrp_pkg::*;

	localparam int LEN_W = $clog2(METHOD_MAX_CHARS + 1);

	logic [2:0]                  phase_q, phase_n;
	logic [8*METHOD_BYTES-1:0]   mchars_q, mchars_n;
	logic [LEN_W-1:0]            mlen_q, mlen_n;
	logic                        query_q, query_n;
	logic [3:0]                  acc_pos_q, acc_pos_n;
	logic [1:0]                  acc_st_q, acc_st_n;
	logic [4:0]                  enc_pos_q, enc_pos_n;
	logic [2:0]                  gz_pos_q, gz_pos_n;
	logic [1:0]                  enc_st_q, enc_st_n;
	logic [2:0]                  err_q, err_n;

	logic       eol;
	logic [2:0] meth_class;
	logic [3:0] acc_step;
	logic [4:0] enc_step;
	logic [2:0] gz_step;
	logic [1:0] enc_fin;

	assign eol = (char_byte == CH_CR) || (char_byte == CH_LF);

	always_comb begin
		meth_class = METH_INVALID;
		for (int i = 0; i < N_METHODS; i++) begin
			if (mlen_q == LEN_W'(METHOD_LENS[i]) && mchars_q == METHOD_WORDS[i]) begin
				meth_class = 3'(i + 1);
			end
		end
	end

	// Pattern matchers; no pattern repeats its first byte, so a miss
	// restarts at one or zero.
	always_comb begin
		if (acc_pos_q < 4'(ACC_PAT_LEN) && char_byte == accept_pat(acc_pos_q[2:0])) begin
			acc_step = acc_pos_q + 4'd1;
		end else begin
			acc_step = (char_byte == accept_pat(3'd0)) ? 4'd1 : 4'd0;
		end
		if (enc_pos_q < 5'(ENC_PAT_LEN) && char_byte == encoding_pat(enc_pos_q)) begin
			enc_step = enc_pos_q + 5'd1;
		end else begin
			enc_step = (char_byte == encoding_pat(5'd0)) ? 5'd1 : 5'd0;
		end
		if (gz_pos_q < 3'(GZIP_PAT_LEN) && char_byte == gzip_pat(gz_pos_q[1:0])) begin
			gz_step = gz_pos_q + 3'd1;
		end else begin
			gz_step = (char_byte == gzip_pat(2'd0)) ? 3'd1 : 3'd0;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		mchars_n  = mchars_q;
		mlen_n    = mlen_q;
		query_n   = query_q;
		acc_pos_n = acc_pos_q;
		acc_st_n  = acc_st_q;
		enc_pos_n = enc_pos_q;
		gz_pos_n  = gz_pos_q;
		enc_st_n  = enc_st_q;
		err_n     = err_q;
		enc_fin   = ENC_NONE;
		pack      = '0;

		unique case (phase_q)
			PH_METHOD: begin
				if (char_byte == CH_SPACE || char_byte == 8'h00 ||
				    mlen_q >= LEN_W'(METHOD_MAX_CHARS)) begin
					if (meth_class == METH_INVALID) begin
						err_n   = ST_BAD_METHOD;
						phase_n = PH_ERROR;
					end else begin
						phase_n = PH_PATH_START;
					end
				end else begin
					if (mlen_q < LEN_W'(METHOD_BYTES)) begin
						mchars_n = {mchars_q[8*METHOD_BYTES-9:0], char_byte};
					end
					mlen_n = mlen_q + LEN_W'(1);
				end
			end
			PH_PATH_START: begin
				if (char_byte == CH_SLASH) begin
					pack.mask[STEP_DATA] = 1'b1;
					pack.kind            = KIND_PATH;
					pack.data            = char_byte;
					phase_n              = PH_PATH;
				end else begin
					err_n   = ST_BAD_PATH;
					phase_n = PH_ERROR;
				end
			end
			PH_PATH: begin
				if (char_byte == CH_SPACE) begin
					phase_n = PH_VERSION;
				end else if (char_byte == CH_QUERY) begin
					query_n = 1'b1;
				end else if (!query_q) begin
					pack.mask[STEP_DATA] = 1'b1;
					pack.kind            = KIND_PATH;
					pack.data            = char_byte;
				end
			end
			PH_VERSION: begin
				if (eol) begin
					phase_n = PH_HEADERS;
				end else begin
					pack.mask[STEP_DATA] = 1'b1;
					pack.kind            = KIND_VERSION;
					pack.data            = char_byte;
				end
			end
			PH_HEADERS: begin
				if (acc_st_q == ACC_SEARCH) begin
					if (acc_step >= 4'(ACC_PAT_LEN)) begin
						acc_st_n  = ACC_VALUE;
						acc_pos_n = '0;
					end else begin
						acc_pos_n = acc_step;
					end
				end else if (acc_st_q == ACC_VALUE) begin
					if (eol) begin
						acc_st_n = ACC_DONE;
					end else begin
						pack.mask[STEP_DATA] = 1'b1;
						pack.kind            = KIND_ACCEPT;
						pack.data            = char_byte;
					end
				end
				if (enc_st_q == ENS_NONE) begin
					if (enc_step >= 5'(ENC_PAT_LEN)) begin
						enc_st_n  = ENS_LINE;
						enc_pos_n = '0;
						gz_pos_n  = '0;
					end else begin
						enc_pos_n = enc_step;
					end
				end else if (enc_st_q == ENS_LINE) begin
					if (eol) begin
						enc_st_n = ENS_UNSUP;
					end else begin
						gz_pos_n = gz_step;
						if (gz_step >= 3'(GZIP_PAT_LEN)) begin
							enc_st_n = ENS_GZIP;
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (end_of_request) begin
			pack.mask[STEP_SUMMARY] = 1'b1;
			// The word is only complete once the phase has left method.
			pack.meth = (phase_n != PH_METHOD && err_n != ST_BAD_METHOD) ?
				meth_class : METH_INVALID;
			if (err_n != ST_OK) begin
				pack.st = err_n;
			end else if (phase_n != PH_HEADERS) begin
				pack.st = ST_TRUNCATED;
			end else begin
				priority if (enc_st_n == ENS_GZIP) begin
					enc_fin = ENC_GZIP;
				end else if (enc_st_n == ENS_LINE || enc_st_n == ENS_UNSUP) begin
					enc_fin = ENC_UNSUP;
				end else begin
					enc_fin = ENC_NONE;
				end
				pack.enc = enc_fin;
				pack.st  = (enc_fin == ENC_UNSUP) ? ST_BAD_ENC : ST_OK;
				if (acc_st_n == ACC_SEARCH) begin
					pack.mask[STEP_DEF0] = 1'b1;
					pack.mask[STEP_DEF1] = 1'b1;
					pack.mask[STEP_DEF2] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_METHOD;
			mchars_q  <= '0;
			mlen_q    <= '0;
			query_q   <= 1'b0;
			acc_pos_q <= '0;
			acc_st_q  <= ACC_SEARCH;
			enc_pos_q <= '0;
			gz_pos_q  <= '0;
			enc_st_q  <= ENS_NONE;
			err_q     <= ST_OK;
		end else if (accept) begin
			if (end_of_request) begin
				phase_q   <= PH_METHOD;
				mchars_q  <= '0;
				mlen_q    <= '0;
				query_q   <= 1'b0;
				acc_pos_q <= '0;
				acc_st_q  <= ACC_SEARCH;
				enc_pos_q <= '0;
				gz_pos_q  <= '0;
				enc_st_q  <= ENS_NONE;
				err_q     <= ST_OK;
			end else begin
				phase_q   <= phase_n;
				mchars_q  <= mchars_n;
				mlen_q    <= mlen_n;
				query_q   <= query_n;
				acc_pos_q <= acc_pos_n;
				acc_st_q  <= acc_st_n;
				enc_pos_q <= enc_pos_n;
				gz_pos_q  <= gz_pos_n;
				enc_st_q  <= enc_st_n;
				err_q     <= err_n;
			end
		end
	end

endmodule

// ===== rtl/hrp_emitter.sv =====
// Pack register and output register: walks the results of one request byte
// onto the result channel one a cycle while not stalled. Depends on hrp_pkg.
module hrp_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  hrp_pkg::hrp_pack_t pack,
	output logic               pack_free,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         item_kind,
	output logic [7:0]         data_byte,
	output logic [2:0]         method_code,
	output logic [1:0]         encoding_code,
	output logic [2:0]         status_code,
	output logic               last_result
);
	import hrp_pkg::*;

	hrp_pack_t          pack_s1;
	logic [N_STEPS-1:0] sel;
	logic [N_STEPS-1:0] mask_left;
	logic               out_free;
	logic               move;

	logic [1:0] kind_d;
	logic [7:0] data_d;
	logic [2:0] meth_d;
	logic [1:0] enc_d;
	logic [2:0] st_d;
	logic       last_d;

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [2:0] meth_q;
	logic [1:0] enc_q;
	logic [2:0] st_q;
	logic       last_q;

	// Lowest pending step goes first.
	assign sel       = pack_s1.mask & (~pack_s1.mask + N_STEPS'(1));
	assign out_free  = !valid_q || !result_stall;
	assign move      = (pack_s1.mask != '0) && out_free;
	assign mask_left = move ? (pack_s1.mask & ~sel) : pack_s1.mask;
	assign pack_free = (mask_left == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_s1 <= '0;
		end else if (load) begin
			pack_s1 <= pack;
		end else begin
			pack_s1.mask <= mask_left;
		end
	end

	always_comb begin
		kind_d = KIND_ACCEPT;
		data_d = CH_STAR;
		meth_d = METH_INVALID;
		enc_d  = ENC_NONE;
		st_d   = ST_OK;
		last_d = 1'b0;
		priority if (sel[STEP_DATA]) begin
			kind_d = pack_s1.kind;
			data_d = pack_s1.data;
		end else if (sel[STEP_DEF1]) begin
			data_d = CH_SLASH;
		end else if (sel[STEP_SUMMARY]) begin
			kind_d = KIND_SUMMARY;
			data_d = 8'h00;
			meth_d = pack_s1.meth;
			enc_d  = pack_s1.enc;
			st_d   = pack_s1.st;
			last_d = 1'b1;
		end else begin
			data_d = CH_STAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= move;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			kind_q <= kind_d;
			data_q <= data_d;
			meth_q <= meth_d;
			enc_q  <= enc_d;
			st_q   <= st_d;
			last_q <= last_d;
		end
	end

	assign result_valid  = valid_q;
	assign item_kind     = kind_q;
	assign data_byte     = data_q;
	assign method_code   = meth_q;
	assign encoding_code = enc_q;
	assign status_code   = st_q;
	assign last_result   = last_q;

endmodule

// ===== rtl/http_request_header_parser.sv =====
// HTTP request line and header parser, top level. Uses hrp_parser, hrp_emitter.
// An accepted byte's results pass through the pack register and then the output
// register to the result port; a stalled result side holds them in place.
// Throughput: one byte a cycle while each byte yields at most one result and
// the result side is not stalled; a byte that yields more results holds the
// byte channel until its last result moves to the single result port's register.
// Async active-low reset restores the method phase, empties pack and output regs.
module http_request_header_parser #(
	parameter int METHOD_MAX_CHARS = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_byte,
	input  logic       end_of_request,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] item_kind,
	output logic [7:0] data_byte,
	output logic [2:0] method_code,
	output logic [1:0] encoding_code,
	output logic [2:0] status_code,
	output logic       last_result
);
	import hrp_pkg::*;

	hrp_pack_t pack;
	logic      pack_free;
	logic      accept;

	assign char_stall = !pack_free;
	assign accept     = char_valid && pack_free;

	hrp_parser #(
		.METHOD_MAX_CHARS(METHOD_MAX_CHARS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.char_byte      (char_byte),
		.end_of_request (end_of_request),
		.pack           (pack)
	);

	hrp_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.pack          (pack),
		.pack_free     (pack_free),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.item_kind     (item_kind),
		.data_byte     (data_byte),
		.method_code   (method_code),
		.encoding_code (encoding_code),
		.status_code   (status_code),
		.last_result   (last_result)
	);

endmodule

// ===== rtl/hrp_checker.sv =====
// Port-level checks for the request header parser, bound to the top level.
// Depends on hrp_pkg.
module hrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] item_kind,
	input logic [7:0] data_byte,
	input logic [2:0] method_code,
	input logic [1:0] encoding_code,
	input logic [2:0] status_code,
	input logic       last_result
);
	import hrp_pkg::*;

	// A stalled result is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(data_byte) &&
		$stable(item_kind))
		else $error("stalled result not held");

	// Only the summary closes a request, and only it carries codes.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last_result == (item_kind == KIND_SUMMARY)))
		else $error("last flag disagrees with result kind");

	a_text_codes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind != KIND_SUMMARY |->
		method_code == METH_INVALID && encoding_code == ENC_NONE &&
		status_code == ST_OK)
		else $error("text result carries summary codes");

	// A good request has a known method and no unsupported encoding.
	a_ok_summary: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind == KIND_SUMMARY && status_code == ST_OK |->
		method_code != METH_INVALID && encoding_code != ENC_UNSUP &&
		data_byte == 8'h00)
		else $error("inconsistent ok summary");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (.*);
